FILE: hdl/pcx_rle_line_decoder_macros.svh
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder assertion macros
// Shared property shorthands for the decoder checker; they expect clk and
// rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_LINE_DECODER_MACROS_SVH
`define PCX_RLE_LINE_DECODER_MACROS_SVH

// same-cycle implication, quiet during reset
`define PCXRLD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcxrld same-cycle check failed");

// next-cycle implication, quiet during reset
`define PCXRLD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcxrld next-cycle check failed");

`endif

FILE: hdl/pcxrld_pkg.sv
// ----------------------------------------------------------------------------
// pcxrld_pkg
// Types, constants and control structs shared by the PCX RLE line decoder.
// ----------------------------------------------------------------------------
package pcxrld_pkg;

  // column counter width, 8 to 16
  localparam int COLUMN_BITS = 16;

  localparam int BYTE_W  = 8;
  localparam int COORD_W = 16;
  localparam int COUNT_W = 6;
  localparam int CFG_IDX_W = 8;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic [COLUMN_BITS-1:0] col_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  // stream byte codes
  localparam byte_t RUN_MARK = 8'hc0;
  localparam byte_t RUN_MASK = 8'h3f;

  localparam col_t COL_MAX = {COLUMN_BITS{1'b1}};

  // configuration register indexes
  localparam cfg_idx_t CFG_LINE_BYTES = 8'd0;
  localparam cfg_idx_t CFG_IMAGE_ROWS = 8'd1;

  localparam coord_t LINE_BYTES_RST = 16'd320;
  localparam coord_t IMAGE_ROWS_RST = 16'd200;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } pcxrld_state_t;

  // controller to datapath
  typedef struct packed {
    logic latch_mark;
    logic latch_run;
    logic emit_lit;
    logic emit_run;
  } pcxrld_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic awaiting;
    logic byte_is_mark;
    logic pending_zero;
    logic left_one;
    logic pix_eol;
  } pcxrld_stat_t;

endpackage

FILE: hdl/pcxrld_ifs.sv
// ----------------------------------------------------------------------------
// pcxrld channel interfaces
// Valid/ready channels for compressed bytes, decoded pixels and config writes.
// ----------------------------------------------------------------------------
interface pcxrld_in_if import pcxrld_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface pcxrld_out_if import pcxrld_pkg::*; ();
  logic   valid;
  logic   ready;
  byte_t  pixel_value;
  coord_t column;
  coord_t row;
  logic   last_of_run;
  logic   end_of_line;
  logic   end_of_image;
  logic   run_clipped;

  modport source (output valid, output pixel_value, output column, output row,
                  output last_of_run, output end_of_line, output end_of_image,
                  output run_clipped, input ready);
  modport sink   (input valid, input pixel_value, input column, input row,
                  input last_of_run, input end_of_line, input end_of_image,
                  input run_clipped, output ready);
endinterface

interface pcxrld_cfg_if import pcxrld_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  coord_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/pcxrld_ctrl.sv
// ----------------------------------------------------------------------------
// pcxrld_ctrl
// Sequencer: takes stream bytes, classifies them and drains runs pixel by
// pixel into the output register.
// ----------------------------------------------------------------------------
module pcxrld_ctrl import pcxrld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  pcxrld_stat_t stat,
  output pcxrld_cmd_t  cmd
);

  pcxrld_state_t state_r, state_nxt;
  logic          accept;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    accept    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = stat.out_free;
        accept   = in_valid && stat.out_free;
        if (accept) begin
          if (stat.awaiting) begin
            cmd.latch_run = 1'b1;
            if (!stat.pending_zero) begin
              state_nxt = ST_RUN;
            end
          end else if (stat.byte_is_mark) begin
            cmd.latch_mark = 1'b1;
          end else begin
            cmd.emit_lit = 1'b1;
          end
        end
      end
      ST_RUN: begin
        // one run pixel per free output slot
        if (stat.out_free) begin
          cmd.emit_run = 1'b1;
          if (stat.left_one || stat.pix_eol) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/pcxrld_dp.sv
// ----------------------------------------------------------------------------
// pcxrld_dp
// Datapath: config registers, run latch, column/row counters and the
// registered output beat.
// ----------------------------------------------------------------------------
module pcxrld_dp import pcxrld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  pcxrld_cmd_t  cmd,
  output pcxrld_stat_t stat,
  input  byte_t        data_byte,
  input  logic         cfg_valid,
  input  cfg_idx_t     cfg_index,
  input  coord_t       cfg_data,
  input  logic         out_ready,
  output logic         out_valid,
  output byte_t        pixel_value,
  output coord_t       column,
  output coord_t       row,
  output logic         last_of_run,
  output logic         end_of_line,
  output logic         end_of_image,
  output logic         run_clipped
);

  coord_t line_bytes_r, image_rows_r;
  logic   awaiting_r;
  count_t pending_r;
  count_t left_r;
  byte_t  value_r;
  col_t   col_r;
  coord_t row_r;

  logic   out_valid_r;
  byte_t  pix_r;
  coord_t ocol_r, orow_r;
  logic   last_r, eol_r, eoi_r, clip_r;

  logic   emit;
  logic   eol, eoi;
  logic   left_one;
  byte_t  pix_nxt;

  // end of line / end of image for the pixel at the current position
  assign eol = ((17'(col_r) + 17'd1) >= {1'b0, line_bytes_r}) || (col_r == COL_MAX);
  assign eoi = eol && ((17'(row_r) + 17'd1) >= {1'b0, image_rows_r});

  assign emit     = cmd.emit_lit || cmd.emit_run;
  assign left_one = (left_r == count_t'(1));
  assign pix_nxt  = cmd.emit_lit ? data_byte : value_r;

  // status to controller
  always_comb begin
    stat.out_free     = !out_valid_r || out_ready;
    stat.awaiting     = awaiting_r;
    stat.byte_is_mark = ((data_byte & RUN_MARK) == RUN_MARK);
    stat.pending_zero = (pending_r == '0);
    stat.left_one     = left_one;
    stat.pix_eol      = eol;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LINE_BYTES_RST;
      image_rows_r <= IMAGE_ROWS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LINE_BYTES: line_bytes_r <= cfg_data;
        CFG_IMAGE_ROWS: image_rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // run marker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      pending_r  <= '0;
    end else if (cmd.latch_mark) begin
      awaiting_r <= 1'b1;
      pending_r  <= count_t'(data_byte & RUN_MASK);
    end else if (cmd.latch_run) begin
      awaiting_r <= 1'b0;
      pending_r  <= '0;
    end
  end

  // run value and remaining count
  always_ff @(posedge clk) begin
    if (cmd.latch_run) begin
      value_r <= data_byte;
      left_r  <= pending_r;
    end else if (cmd.emit_run) begin
      left_r  <= left_r - count_t'(1);
    end
  end

  // column and row counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (emit) begin
      if (eol) begin
        col_r <= '0;
        row_r <= eoi ? '0 : row_r + coord_t'(1);
      end else begin
        col_r <= col_r + col_t'(1);
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      pix_r  <= pix_nxt;
      ocol_r <= coord_t'(col_r);
      orow_r <= row_r;
      last_r <= cmd.emit_lit || left_one || eol;
      eol_r  <= eol;
      eoi_r  <= eoi;
      clip_r <= cmd.emit_run && eol && !left_one;
    end
  end

  assign out_valid    = out_valid_r;
  assign pixel_value  = pix_r;
  assign column       = ocol_r;
  assign row          = orow_r;
  assign last_of_run  = last_r;
  assign end_of_line  = eol_r;
  assign end_of_image = eoi_r;
  assign run_clipped  = clip_r;

endmodule

FILE: hdl/pcx_rle_line_decoder.sv
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder
// PCX run-length decoder that tags each pixel with its column and row.
// ----------------------------------------------------------------------------
// Channels: in_ch takes one compressed byte per beat; out_ch gives one
// decoded pixel per beat with its column, row and the last-of-run,
// end-of-line, end-of-image and clipped-run flags; cfg_ch writes line_bytes
// (index 0) and image_rows (index 1), always ready; the user must write them
// only while the block is idle, which the block does not enforce. A literal
// shows on out_ch in the cycle after it is taken. Literals and run markers
// go one per cycle while out_ch is not stalled. A run value byte then sends
// its pixels (up to 63) one per cycle while out_ch is free, with in_ch held
// off; the single output register sets the pace. A run that reaches the
// line end stops there and flags run_clipped. Reset (synchronous, rst_n low)
// sets line_bytes to 320, image_rows to 200, clears counters and the pending
// run, and drops out_ch valid. When out_ch stalls, the held beat stays put
// and in_ch ready drops until the output register is taken.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder import pcxrld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pcxrld_in_if.sink    in_ch,
  pcxrld_out_if.source out_ch,
  pcxrld_cfg_if.sink   cfg_ch
);

  pcxrld_cmd_t  cmd;
  pcxrld_stat_t stat;

  // config writes are always accepted
  assign cfg_ch.ready = 1'b1;

  pcxrld_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pcxrld_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (in_ch.data_byte),
    .cfg_valid    (cfg_ch.valid),
    .cfg_index    (cfg_ch.index),
    .cfg_data     (cfg_ch.data),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .pixel_value  (out_ch.pixel_value),
    .column       (out_ch.column),
    .row          (out_ch.row),
    .last_of_run  (out_ch.last_of_run),
    .end_of_line  (out_ch.end_of_line),
    .end_of_image (out_ch.end_of_image),
    .run_clipped  (out_ch.run_clipped)
  );

endmodule

FILE: hdl/pcxrld_checker.sv
// ----------------------------------------------------------------------------
// pcxrld_checker
// Port-level checks on the decoder's channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "pcx_rle_line_decoder_macros.svh"

module pcxrld_checker import pcxrld_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input byte_t  pixel_value,
  input coord_t column,
  input coord_t row,
  input logic   last_of_run,
  input logic   end_of_line,
  input logic   end_of_image,
  input logic   run_clipped
);

  logic out_stall;
  logic [BYTE_W+2*COORD_W+3:0] out_payload;

  assign out_stall   = out_valid && !out_ready;
  assign out_payload = {pixel_value, column, row, last_of_run, end_of_line,
                        end_of_image, run_clipped};

  // stalled beat holds its payload
  `PCXRLD_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_payload))

  // image end only on a line end
  `PCXRLD_ASSERT_IMP(a_eoi_on_eol, out_valid && end_of_image, end_of_line)

  // clipping happens only at a line end and closes the run
  `PCXRLD_ASSERT_IMP(a_clip_eol, out_valid && run_clipped, end_of_line && last_of_run)

  // input is never taken while a result is stuck in the output register
  `PCXRLD_ASSERT_IMP(a_in_needs_room, in_valid && in_ready, !out_stall)

endmodule

bind pcx_rle_line_decoder pcxrld_checker u_pcxrld_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .pixel_value  (out_ch.pixel_value),
  .column       (out_ch.column),
  .row          (out_ch.row),
  .last_of_run  (out_ch.last_of_run),
  .end_of_line  (out_ch.end_of_line),
  .end_of_image (out_ch.end_of_image),
  .run_clipped  (out_ch.run_clipped)
);

FILE: tb/pcx_rle_line_decoder_checker.sv
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder checker
// Watches the byte, pixel and config channels of the decoder, keeps its own
// model of the run-length state and the line/image counters, and compares
// every pixel beat field by field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcx_rle_line_decoder_checker import pcxrld_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  pcxrld_in_if         in_ch,
  pcxrld_out_if        out_ch,
  pcxrld_cfg_if        cfg_ch,
  output int           mismatch_count,
  output int           pending_pixels
);

  typedef struct packed {
    byte_t  pixel_value;
    coord_t column;
    coord_t row;
    logic   last_of_run;
    logic   end_of_line;
    logic   end_of_image;
    logic   run_clipped;
  } pixel_beat_t;

  // geometry registers as the decoder should hold them
  coord_t line_len;
  coord_t row_total;

  // decoder state
  logic   run_open;
  count_t run_len;
  col_t   col_pos;
  coord_t row_pos;

  pixel_beat_t pixel_q[$];
  int          errors;

  // place one pixel at the current position and advance the counters
  function automatic pixel_beat_t place_pixel(input byte_t value, output bit eol);
    pixel_beat_t p;
    bit eoi;
    eol = (int'(col_pos) + 1 >= int'(line_len)) || (col_pos == COL_MAX);
    eoi = eol && (int'(row_pos) + 1 >= int'(row_total));
    p.pixel_value  = value;
    p.column       = coord_t'(col_pos);
    p.row          = row_pos;
    p.last_of_run  = 1'b0;
    p.end_of_line  = eol;
    p.end_of_image = eoi;
    p.run_clipped  = 1'b0;
    if (eol) begin
      col_pos = '0;
      row_pos = eoi ? coord_t'(0) : row_pos + coord_t'(1);
    end else begin
      col_pos = col_pos + col_t'(1);
    end
    return p;
  endfunction

  // expand one stream byte into the pixels it produces
  function automatic void decode_byte(input byte_t b);
    pixel_beat_t p;
    int unsigned left;
    bit          eol;
    if (!run_open) begin
      if ((b & RUN_MARK) == RUN_MARK) begin
        run_len  = count_t'(b & RUN_MASK);
        run_open = 1'b1;
      end else begin
        p = place_pixel(b, eol);
        p.last_of_run = 1'b1;
        pixel_q.push_back(p);
      end
    end else begin
      run_open = 1'b0;
      left     = run_len;
      run_len  = '0;
      eol      = 1'b0;
      while (left > 0 && !eol) begin
        p = place_pixel(b, eol);
        left--;
        if (left == 0 || eol) begin
          p.last_of_run = 1'b1;
          p.run_clipped = (left > 0);
        end
        pixel_q.push_back(p);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // sample all channels at the edge, pixel side first
  always @(posedge clk) begin
    pixel_beat_t want;
    if (!rst_n) begin
      line_len  = LINE_BYTES_RST;
      row_total = IMAGE_ROWS_RST;
      run_open  = 1'b0;
      run_len   = '0;
      col_pos   = '0;
      row_pos   = '0;
      pixel_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel beat with none expected: value %0d column %0d row %0d",
                 out_ch.pixel_value, out_ch.column, out_ch.row);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_value", want.pixel_value, out_ch.pixel_value);
          check_field("column", want.column, out_ch.column);
          check_field("row", want.row, out_ch.row);
          check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
          check_field("end_of_line", want.end_of_line, out_ch.end_of_line);
          check_field("end_of_image", want.end_of_image, out_ch.end_of_image);
          check_field("run_clipped", want.run_clipped, out_ch.run_clipped);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_LINE_BYTES: line_len = cfg_ch.data;
          CFG_IMAGE_ROWS: row_total = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte);
      end
    end
    mismatch_count <= errors;
    pending_pixels <= pixel_q.size();
  end

endmodule

FILE: tb/pcx_rle_line_decoder_tb.sv
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder testbench
// Drives compressed PCX byte streams through the decoder under several line
// and image geometries: a directed opening for the corner cases, then random
// literals and runs with bursty idling on both channels and one long output
// hold-off. A side checker predicts and compares every pixel beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcx_rle_line_decoder_tb;
  import pcxrld_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_BYTES   = 43;
  localparam int RAND_PHASES   = 7;

  logic clk;
  logic rst_n;

  pcxrld_in_if  in_ch ();
  pcxrld_out_if out_ch ();
  pcxrld_cfg_if cfg_ch ();

  int mismatch_count;
  int pending_pixels;
  int unsigned quiet_cycles;

  // idling controls for the byte sender and the pixel receiver process
  bit tx_idle;
  bit rx_idle;
  bit long_hold_req;
  bit long_hold_taken;

  pcx_rle_line_decoder i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  pcx_rle_line_decoder_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatch_count (mismatch_count),
    .pending_pixels (pending_pixels)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycles with no beat on any channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("pcx_rle_line_decoder verification failed");
    $finish;
  end

  // pixel receiver: ready bursts, idle bursts and one long hold-off
  initial begin : pixel_receiver
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_taken) begin
        long_hold_taken = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // one byte beat, with an optional idle burst ahead of it
  task automatic send_byte(input byte_t b);
    if (tx_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_run(input int unsigned count, input byte_t value);
    send_byte(RUN_MARK | byte_t'(count));
    send_byte(value);
  endtask

  // random literal, run, or raw noise byte (with a follower if it is a marker)
  task automatic send_random_token(inout int unsigned sent);
    int unsigned pick;
    int unsigned count;
    byte_t       raw;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_byte(byte_t'($urandom_range(0, 8'hbf)));
      sent += 1;
    end else if (pick < 90) begin
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 8);
      send_run(count, byte_t'($urandom_range(0, 255)));
      sent += 2;
    end else begin
      raw = byte_t'($urandom_range(0, 255));
      send_byte(raw);
      sent += 1;
      if ((raw & RUN_MARK) == RUN_MARK) begin
        send_byte(byte_t'($urandom_range(0, 255)));
        sent += 1;
      end
    end
  endtask

  // stop sending and wait until every predicted pixel has come out
  task automatic end_phase();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input coord_t line_len, input coord_t rows);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_LINE_BYTES;
    cfg_ch.data  <= line_len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= CFG_IMAGE_ROWS;
    cfg_ch.data  <= rows;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned sent;
    coord_t      line_len;
    coord_t      rows;

    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_LINE_BYTES;
    cfg_ch.data     <= '0;
    rst_n           <= 1'b0;
    tx_idle         = 1'b1;
    rx_idle         = 1'b1;
    long_hold_req   = 1'b0;
    long_hold_taken = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry: literal extremes, empty run, full run, marker-like value
    send_byte(8'h00);
    send_byte(8'hbf);
    send_run(0, 8'h12);
    send_run(63, 8'hff);
    send_run(2, 8'hc5);
    end_phase();

    // 5x3 image: clipped run, exact line end, run ending the image
    set_geometry(16'd5, 16'd3);
    send_run(8, 8'h3c);
    send_byte(8'h01);
    send_byte(8'h40);
    send_byte(8'h80);
    send_run(2, 8'h7e);
    send_run(5, 8'h9a);
    send_byte(8'h02);
    end_phase();

    // zero geometry: every pixel ends its line and the image
    set_geometry(16'd0, 16'd0);
    send_byte(8'h21);
    send_run(3, 8'h11);
    end_phase();

    // widest line, then shrink it while the column is far along
    set_geometry(16'hffff, 16'hffff);
    send_run(63, 8'h80);
    send_byte(8'h7f);
    end_phase();
    set_geometry(16'd4, 16'd2);
    send_byte(8'h33);
    send_run(5, 8'hc0);
    end_phase();

    // random phases over a spread of geometries and idling modes
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: begin line_len = 16'd1;     rows = 16'd1;     end
        2: begin line_len = 16'hffff;  rows = 16'd1;     end
        4: begin line_len = 16'd1;     rows = 16'hffff;  end
        default: begin
          line_len = coord_t'($urandom_range(1, 24));
          rows     = coord_t'($urandom_range(1, 5));
        end
      endcase
      set_geometry(line_len, rows);
      tx_idle = (phase % 4 == 0) || (phase % 4 == 1);
      rx_idle = (phase % 4 == 0) || (phase % 4 == 2);
      if (phase == 3) begin
        tx_idle       = 1'b0;
        long_hold_req = 1'b1;
      end
      if (phase == RAND_PHASES - 1) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      sent = 0;
      while (sent < PHASE_BYTES) send_random_token(sent);
      end_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("pcx_rle_line_decoder verification clean");
    end else begin
      $display("pcx_rle_line_decoder verification failed");
    end
    $finish;
  end

endmodule
